[rtl/pcg_pkg.sv]
// shared types, register codes and fixed-point helpers for the plane crossing core
// no dependencies; used by every module of the block
package pcg_pkg;

    typedef enum logic [1:0] {
        REG_NORMAL_X = 2'd0,
        REG_NORMAL_Y = 2'd1,
        REG_NORMAL_Z = 2'd2,
        REG_OFFSET   = 2'd3
    } reg_idx_t;

    typedef struct {
        logic signed [17:0] n [3];
        logic signed [31:0] off;
    } cfg_t;

    // one item as it travels down the pipeline
    typedef struct {
        logic               op;
        logic [30:0]        dt;
        logic signed [31:0] t;
        logic signed [31:0] q [3];
        logic signed [31:0] v [3];
        logic signed [31:0] g [3];
        logic signed [49:0] pr_nq [3];
        logic signed [49:0] pr_nv [3];
        logic signed [63:0] pr_vg [3];
        logic signed [63:0] pr_tg [3];
        logic signed [51:0] p;
        logic signed [51:0] d;
        logic signed [31:0] w;
        logic signed [47:0] tgr [3];
        logic               dz;
        logic               wsat;
        logic               asat;
        logic               bsat;
        logic               ksat;
        logic               gsat;
        logic               nega;
        logic               negb;
        logic               ovfa;
        logic               ovfb;
        logic               hit;
        logic               par;
        logic               sat;
        logic [50:0]        ud;
        logic [50:0]        absp;
        logic [50:0]        ra;
        logic [50:0]        rb;
        logic [31:0]        la;
        logic [31:0]        lb;
        logic [56:0]        pd_lo;
        logic [55:0]        pd_hi;
        logic signed [31:0] qa;
        logic signed [31:0] qb;
        logic signed [63:0] pr_ce;
        logic signed [49:0] pr_cn [3];
        logic signed [31:0] k;
        logic signed [49:0] pr_kn [3];
        logic signed [31:0] hit_time;
        logic signed [31:0] gq [3];
        logic signed [31:0] gv [3];
    } pipe_t;

    // round a q32.32 product to q32.16 (48 bit), half up
    function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] tmp;
        tmp = x + 64'sd32768;
        return tmp[63:16];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] x);
        return (x > 64'sd2147483647) || (x < -64'sd2147483648);
    endfunction

    // quotient magnitude to signed q16.16 with clamp, msb is the clamp flag
    function automatic logic [32:0] qfin(input logic [31:0] m, input logic ovf,
                                         input logic neg);
        if (ovf)
            return {1'b1, neg ? 32'h80000000 : 32'h7FFFFFFF};
        if (!neg && m > 32'h7FFFFFFF)
            return {1'b1, 32'h7FFFFFFF};
        if (neg && m > 32'h80000000)
            return {1'b1, 32'h80000000};
        return {1'b0, neg ? (~m + 32'h1) : m};
    endfunction

endpackage

[rtl/pcg_front.sv]
// front pipeline: dot products, offset, signs, divider setup and stepped-point test
// depends on pcg_pkg
module pcg_front (
    input  logic           clk,
    input  logic           rst_n,
    input  pcg_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  pcg_pkg::pipe_t in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output pcg_pkg::pipe_t out_item
);

    localparam int NST = 5;

    pcg_pkg::pipe_t st_reg  [NST];
    pcg_pkg::pipe_t st_next [NST];
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ld;

    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            ld[k] = !vld_reg[k] || ld[k+1];
    end

    always_comb
    begin
        pcg_pkg::pipe_t     it;
        logic signed [63:0] wsum;
        logic signed [51:0] tmp;
        logic signed [32:0] aw;
        logic [31:0]        awu;
        logic               pa;
        logic               nxt;
        logic [81:0]        prod;
        logic [81:0]        pw;

        // products
        it = in_item;
        for (int i = 0; i < 3; i++)
        begin
            it.pr_nq[i] = cfg.n[i] * in_item.q[i];
            it.pr_nv[i] = cfg.n[i] * in_item.v[i];
            it.pr_vg[i] = in_item.v[i] * in_item.g[i];
            it.pr_tg[i] = in_item.t * in_item.g[i];
        end
        st_next[0] = it;

        // sums and rounding
        it = st_reg[0];
        it.p = $signed({{4{cfg.off[31]}}, cfg.off, 16'h0000})
             + it.pr_nq[0] + it.pr_nq[1] + it.pr_nq[2];
        it.d = it.pr_nv[0] + it.pr_nv[1] + it.pr_nv[2];
        wsum = pcg_pkg::rnd16(it.pr_vg[0]) + pcg_pkg::rnd16(it.pr_vg[1])
             + pcg_pkg::rnd16(it.pr_vg[2]);
        it.w    = pcg_pkg::clamp32(wsum);
        it.wsat = pcg_pkg::ovf32(wsum);
        for (int i = 0; i < 3; i++)
            it.tgr[i] = pcg_pkg::rnd16(it.pr_tg[i]);
        st_next[1] = it;

        // magnitudes, quotient signs, overflow checks, divider start
        it = st_reg[1];
        it.dz = (it.d == 52'sd0);
        tmp = it.d[51] ? -it.d : it.d;
        it.ud = tmp[50:0];
        tmp = it.p[51] ? -it.p : it.p;
        it.absp = tmp[50:0];
        pa = !it.p[51] && (it.p != 52'sd0);
        it.nega = (it.op ? it.p[51] : pa) != it.d[51];
        aw = it.w[31] ? -{it.w[31], it.w} : {it.w[31], it.w};
        awu = aw[31:0];
        it.negb = (!it.w[31] && (it.w != 32'sd0)) != it.d[51];
        it.ovfa = {16'h0000, it.absp} >= {it.ud, 16'h0000};
        it.ovfb = {19'h00000, awu, 16'h0000} >= {it.ud, 16'h0000};
        it.ra = {16'h0000, it.absp[50:16]};
        it.la = {it.absp[15:0], 16'h0000};
        it.rb = {19'h00000, awu};
        it.lb = 32'h0;
        st_next[2] = it;

        // step times normal speed, split in two halves
        it = st_reg[2];
        it.pd_lo = it.dt * it.ud[25:0];
        it.pd_hi = it.dt * it.ud[50:26];
        st_next[3] = it;

        // stepped point above test
        it = st_reg[3];
        prod = {it.pd_hi, 26'h0} + {25'h0, it.pd_lo};
        pw   = {15'h0, it.absp, 16'h0000};
        pa   = !it.p[51] && (it.p != 52'sd0);
        if (it.dt == 31'h0 || it.dz)
            nxt = pa;
        else if (pa && !it.d[51])
            nxt = 1'b1;
        else if (!pa && it.d[51])
            nxt = 1'b0;
        else
            nxt = pa ? (pw > prod) : (prod > pw);
        it.hit = !(pa && nxt);
        st_next[4] = it;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (ld[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
            if (ld[k])
                st_reg[k] <= st_next[k];
    end

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[NST-1];
    assign out_item  = st_reg[NST-1];

endmodule

[rtl/pcg_div.sv]
// pipelined restoring divider, one quotient bit per stage, two lanes side by side
// depends on pcg_pkg
module pcg_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pcg_pkg::pipe_t in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output pcg_pkg::pipe_t out_item
);

    localparam int NST = 32;

    pcg_pkg::pipe_t st_reg  [NST];
    pcg_pkg::pipe_t st_next [NST];
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ld;

    // shift next dividend bit into the remainder, subtract when it fits
    function automatic logic [82:0] dstep(input logic [50:0] r, input logic [31:0] l,
                                          input logic [50:0] ud);
        logic [51:0] rs;
        logic [51:0] df;
        rs = {r, l[31]};
        df = rs - {1'b0, ud};
        if (rs >= {1'b0, ud})
            return {df[50:0], l[30:0], 1'b1};
        return {rs[50:0], l[30:0], 1'b0};
    endfunction

    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            ld[k] = !vld_reg[k] || ld[k+1];
    end

    always_comb
    begin
        pcg_pkg::pipe_t it;
        it = in_item;
        {it.ra, it.la} = dstep(it.ra, it.la, it.ud);
        {it.rb, it.lb} = dstep(it.rb, it.lb, it.ud);
        st_next[0] = it;
        for (int k = 1; k < NST; k++)
        begin
            it = st_reg[k-1];
            {it.ra, it.la} = dstep(it.ra, it.la, it.ud);
            {it.rb, it.lb} = dstep(it.rb, it.lb, it.ud);
            st_next[k] = it;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (ld[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
            if (ld[k])
                st_reg[k] <= st_next[k];
    end

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[NST-1];
    assign out_item  = st_reg[NST-1];

endmodule

[rtl/pcg_back.sv]
// back pipeline: quotient clamp, gradient products and result assembly
// depends on pcg_pkg
module pcg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pcg_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  pcg_pkg::pipe_t in_item,
    output logic           out_valid,
    input  logic           out_stall,
    output pcg_pkg::pipe_t out_item
);

    localparam int NST = 5;

    pcg_pkg::pipe_t st_reg  [NST];
    pcg_pkg::pipe_t st_next [NST];
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ld;

    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            ld[k] = !vld_reg[k] || ld[k+1];
    end

    always_comb
    begin
        pcg_pkg::pipe_t     it;
        logic signed [63:0] x;
        logic signed [31:0] gvv [3];
        logic               gs;

        // signed quotients: qa is the crossing time or e, qb is c
        it = in_item;
        {it.asat, it.qa} = pcg_pkg::qfin(it.la, it.ovfa, it.nega);
        {it.bsat, it.qb} = pcg_pkg::qfin(it.lb, it.ovfb, it.negb);
        st_next[0] = it;

        it = st_reg[0];
        it.pr_ce = it.qb * it.qa;
        for (int i = 0; i < 3; i++)
            it.pr_cn[i] = it.qb * cfg.n[i];
        st_next[1] = it;

        // coefficient k and position gradient
        it = st_reg[1];
        x = 64'sd0 - pcg_pkg::rnd16(it.pr_ce);
        it.k    = pcg_pkg::clamp32(x);
        it.ksat = pcg_pkg::ovf32(x);
        gs = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            x = it.g[i] + pcg_pkg::rnd16(it.pr_cn[i]);
            it.gq[i] = pcg_pkg::clamp32(x);
            gs = gs | pcg_pkg::ovf32(x);
        end
        it.gsat = gs;
        st_next[2] = it;

        it = st_reg[2];
        for (int i = 0; i < 3; i++)
            it.pr_kn[i] = it.k * cfg.n[i];
        st_next[3] = it;

        // velocity gradient and result assembly
        it = st_reg[3];
        gs = it.gsat;
        for (int i = 0; i < 3; i++)
        begin
            x = pcg_pkg::rnd16(it.pr_kn[i]) + it.tgr[i];
            gvv[i] = pcg_pkg::clamp32(x);
            gs = gs | pcg_pkg::ovf32(x);
        end
        if (!it.op)
        begin
            it.par      = it.hit && it.dz;
            it.sat      = it.hit && !it.dz && it.asat;
            it.hit_time = (it.hit && !it.dz) ? it.qa : 32'sd0;
            for (int i = 0; i < 3; i++)
            begin
                it.gq[i] = 32'sd0;
                it.gv[i] = 32'sd0;
            end
        end
        else
        begin
            it.hit      = 1'b0;
            it.hit_time = 32'sd0;
            it.par      = it.dz;
            it.sat      = !it.dz && (it.wsat || it.asat || it.bsat || it.ksat || gs);
            for (int i = 0; i < 3; i++)
            begin
                it.gv[i] = it.dz ? 32'sd0 : gvv[i];
                if (it.dz)
                    it.gq[i] = 32'sd0;
            end
        end
        st_next[4] = it;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ld[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (ld[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
            if (ld[k])
                st_reg[k] <= st_next[k];
    end

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[NST-1];
    assign out_item  = st_reg[NST-1];

`ifndef SYNTHESIS
    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.par |-> out_item.gq[0] == 32'sd0 && out_item.gq[1] == 32'sd0
            && out_item.gq[2] == 32'sd0 && out_item.gv[0] == 32'sd0
            && out_item.gv[1] == 32'sd0 && out_item.gv[2] == 32'sd0)
        else $error("parallel result with nonzero gradient");
    a_fwd_grad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.op |-> out_item.gq[0] == 32'sd0 && out_item.gv[0] == 32'sd0
            && out_item.gq[2] == 32'sd0 && out_item.gv[2] == 32'sd0)
        else $error("forward result carries gradient");
    a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.op && !out_item.hit |-> !out_item.sat && !out_item.par
            && out_item.hit_time == 32'sd0)
        else $error("miss with nonzero fields");
`endif

endmodule

[rtl/plane_crossing_time_and_gradient_core.sv]
// top level of the plane crossing time and gradient core: ports, plane registers
// depends on pcg_pkg, pcg_front, pcg_div, pcg_back
//
// usage
// - request channel: in_valid/in_stall, taken at a clock edge with in_valid high and
//   in_stall low; opcode 0 is the forward crossing test, opcode 1 the gradient pass
// - result channel: out_valid/out_stall, one result per request, in request order
// - plane registers written over cfg_valid/cfg_ready/cfg_index/cfg_data while idle;
//   cfg_ready is always high, index 0..2 normal x/y/z (18 bit), 3 plane offset
// - pipeline: 42 register stages (5 front, 32 divider, 5 back)
// - throughput: one request per cycle while no stall holds the pipeline, set by the
//   divider retiring one quotient bit per stage in each of its two lanes
// - a stall on the result side holds the last stage; earlier stages keep filling
//   their empty slots, and in_stall rises only once every stage is occupied
// - reset clears all stage valid bits and loads the default plane x = 0
//   (normal 1.0 along x, offset 0)
module plane_crossing_time_and_gradient_core #(
    parameter int DIMENSION = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic [31:0] vel_z,
    input  logic [30:0] step_time,
    input  logic [31:0] given_hit_time,
    input  logic [31:0] up_grad_x,
    input  logic [31:0] up_grad_y,
    input  logic [31:0] up_grad_z,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        parallel,
    output logic        saturated,
    output logic [31:0] hit_time,
    output logic [31:0] grad_pos_x,
    output logic [31:0] grad_pos_y,
    output logic [31:0] grad_pos_z,
    output logic [31:0] grad_vel_x,
    output logic [31:0] grad_vel_y,
    output logic [31:0] grad_vel_z,
    // plane register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // z lane is dropped in the planar case
    localparam logic USE_Z = (DIMENSION > 2);

    logic signed [17:0] normal_x_reg;
    logic signed [17:0] normal_y_reg;
    logic signed [17:0] normal_z_reg;
    logic signed [31:0] offset_reg;

    pcg_pkg::cfg_t  cfg;
    pcg_pkg::pipe_t in_item;
    pcg_pkg::pipe_t fr_item;
    pcg_pkg::pipe_t dv_item;
    pcg_pkg::pipe_t res_item;
    logic           fr_valid;
    logic           fr_stall;
    logic           dv_valid;
    logic           dv_stall;

    assign cfg_ready = 1'b1;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= 18'sd65536;
            normal_y_reg <= 18'sd0;
            normal_z_reg <= 18'sd0;
            offset_reg   <= 32'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pcg_pkg::reg_idx_t'(cfg_index))
                pcg_pkg::REG_NORMAL_X: normal_x_reg <= cfg_data[17:0];
                pcg_pkg::REG_NORMAL_Y: normal_y_reg <= cfg_data[17:0];
                pcg_pkg::REG_NORMAL_Z: normal_z_reg <= cfg_data[17:0];
                pcg_pkg::REG_OFFSET:   offset_reg   <= cfg_data;
                default:               offset_reg   <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.n[0] = normal_x_reg;
        cfg.n[1] = normal_y_reg;
        cfg.n[2] = USE_Z ? normal_z_reg : 18'sd0;
        cfg.off  = offset_reg;
    end

    // request fields into the pipeline item, z masked in the planar case
    always_comb
    begin
        in_item      = '{default: '0};
        in_item.op   = opcode;
        in_item.dt   = step_time;
        in_item.t    = given_hit_time;
        in_item.q[0] = pos_x;
        in_item.q[1] = pos_y;
        in_item.q[2] = USE_Z ? pos_z : 32'h0;
        in_item.v[0] = vel_x;
        in_item.v[1] = vel_y;
        in_item.v[2] = USE_Z ? vel_z : 32'h0;
        in_item.g[0] = up_grad_x;
        in_item.g[1] = up_grad_y;
        in_item.g[2] = USE_Z ? up_grad_z : 32'h0;
    end

    pcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (fr_valid),
        .out_stall (fr_stall),
        .out_item  (fr_item)
    );

    pcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_stall (dv_stall),
        .out_item  (dv_item)
    );

    pcg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (dv_valid),
        .in_stall  (dv_stall),
        .in_item   (dv_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (res_item)
    );

    // result fields
    assign hit        = res_item.hit;
    assign parallel   = res_item.par;
    assign saturated  = res_item.sat;
    assign hit_time   = res_item.hit_time;
    assign grad_pos_x = res_item.gq[0];
    assign grad_pos_y = res_item.gq[1];
    assign grad_pos_z = res_item.gq[2];
    assign grad_vel_x = res_item.gv[0];
    assign grad_vel_y = res_item.gv[1];
    assign grad_vel_z = res_item.gv[2];

endmodule
